/* rtl/tcs_pkg.sv */
// Shared types and constants of the trajectory cube segmenter.
// Holds the register map, the register bank layout and the CORDIC angle table.
// No dependencies.
package tcs_pkg;

    localparam int STEP_W   = 24;
    localparam int TW_W     = 17;
    localparam int SCALE_W  = 16;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 17;
    localparam int CFG_DW   = 24;
    localparam int CFG_IW   = 3;
    localparam int HEAD_W   = 9;
    localparam int SPAN_W   = 32;
    localparam int CIDX_W   = 16;
    localparam int ANG_W    = 25;
    localparam int CORDIC_STEPS = 22;

    // angles in 2^-16 degree
    localparam logic [23:0] ANG_90   = 24'd5898240;
    localparam logic [23:0] ANG_180  = 24'd11796480;
    localparam logic [23:0] HALF_DEG = 24'd32768;

    typedef enum logic [CFG_IW-1:0] {
        REG_STEP_X       = 3'd0,
        REG_STEP_Y       = 3'd1,
        REG_TIME_WINDOW  = 3'd2,
        REG_SCALE_METERS = 3'd3,
        REG_USER_ID      = 3'd4,
        REG_TRAJ_ID      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_x;
        logic [STEP_W-1:0]  step_y;
        logic [TW_W-1:0]    time_window;
        logic [SCALE_W-1:0] scale_meters;
        logic [ID_W-1:0]    user_id;
        logic [ID_W-1:0]    traj_id;
    } cfg_t;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        unique case (i)
            5'd0:    a = 25'd2949120;
            5'd1:    a = 25'd1740967;
            5'd2:    a = 25'd919879;
            5'd3:    a = 25'd466945;
            5'd4:    a = 25'd234379;
            5'd5:    a = 25'd117304;
            5'd6:    a = 25'd58666;
            5'd7:    a = 25'd29335;
            5'd8:    a = 25'd14668;
            5'd9:    a = 25'd7334;
            5'd10:   a = 25'd3667;
            5'd11:   a = 25'd1833;
            5'd12:   a = 25'd917;
            5'd13:   a = 25'd458;
            5'd14:   a = 25'd229;
            5'd15:   a = 25'd115;
            5'd16:   a = 25'd57;
            5'd17:   a = 25'd29;
            5'd18:   a = 25'd14;
            5'd19:   a = 25'd7;
            5'd20:   a = 25'd4;
            5'd21:   a = 25'd2;
            default: a = 25'd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/tcs_calc.sv */
// Cube arithmetic: heading by iterative CORDIC, distance by serial divide
// and two-bit-per-cycle square root. Depends on tcs_pkg.
module tcs_calc #(
    parameter int COORD_BITS = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [COORD_BITS-1:0]       first_x,
    input  logic [COORD_BITS-1:0]       first_y,
    input  logic [COORD_BITS-1:0]       final_x,
    input  logic [COORD_BITS-1:0]       final_y,
    input  tcs_pkg::cfg_t               cfg,
    output logic                        done,
    output logic signed [8:0]           heading_deg,
    output logic [31:0]                 span_dist
);
    import tcs_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int P   = C + SCALE_W;
    localparam int PCW = $clog2(P);
    localparam int CDW = C + 19;

    typedef enum logic [2:0] {C_IDLE, C_MUL, C_DIV, C_SQ, C_SUM, C_ROOT, C_DONE} cstate_t;
    cstate_t cstate_reg;

    logic [C-1:0]          adx_reg, ady_reg;
    logic                  negx_reg, negy_reg, zero_reg;
    logic [P-1:0]          nx_reg, ny_reg;
    logic [STEP_W-1:0]     rx_reg, ry_reg, dvx_reg, dvy_reg;
    logic [PCW-1:0]        dcnt_reg;
    logic [63:0]           sqx_reg, sqy_reg, rad_reg;
    logic                  sat_reg;
    logic [33:0]           rem_reg;
    logic [31:0]           root_reg, span_reg;
    logic [4:0]            rcnt_reg, ci_reg;
    logic signed [CDW-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0] cz_reg;
    logic                  crun_reg;
    logic signed [8:0]     hd_reg;

    logic            negx, negy;
    logic [C-1:0]    adx, ady;
    logic [STEP_W:0] shx, shy;
    logic            gex, gey;
    logic signed [CDW-1:0] xs, ys;
    logic signed [ANG_W-1:0] at;
    logic [23:0]     zc, m, mm;
    logic [24:0]     mp;
    logic signed [8:0] hd;
    logic [64:0]     ssum;
    logic [35:0]     rsh, trial;
    logic            rge;

    assign negx = final_x < first_x;
    assign negy = final_y < first_y;
    assign adx  = negx ? first_x - final_x : final_x - first_x;
    assign ady  = negy ? first_y - final_y : final_y - first_y;

    // one restoring divide step per lane
    assign shx = {rx_reg, nx_reg[P-1]};
    assign shy = {ry_reg, ny_reg[P-1]};
    assign gex = shx >= {1'b0, dvx_reg};
    assign gey = shy >= {1'b0, dvy_reg};

    assign xs = cx_reg >>> ci_reg;
    assign ys = cy_reg >>> ci_reg;
    assign at = $signed(atan_entry(ci_reg));

    // clamp, fold to quadrant; round half up above the x axis, below it take half a degree off and truncate
    always_comb
    begin
        if (cz_reg < 0)
            zc = 24'd0;
        else if (cz_reg > $signed({1'b0, ANG_90}))
            zc = ANG_90;
        else
            zc = cz_reg[23:0];
        m  = negx_reg ? ANG_180 - zc : zc;
        mp = {1'b0, m} + {1'b0, HALF_DEG};
        mm = m - HALF_DEG;
        if (zero_reg)
            hd = 9'sd0;
        else if (!negy_reg)
            hd = $signed(9'(mp >> 16));
        else if (m < HALF_DEG)
            hd = 9'sd0;
        else
            hd = -$signed(9'(mm >> 16));
    end

    assign ssum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign rsh   = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign rge   = rsh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstate_reg <= C_IDLE;
            crun_reg   <= 1'b0;
            adx_reg <= '0; ady_reg <= '0;
            negx_reg <= 1'b0; negy_reg <= 1'b0; zero_reg <= 1'b1;
            nx_reg <= '0; ny_reg <= '0; rx_reg <= '0; ry_reg <= '0;
            dvx_reg <= '0; dvy_reg <= '0; dcnt_reg <= '0;
            sqx_reg <= '0; sqy_reg <= '0; rad_reg <= '0; sat_reg <= 1'b0;
            rem_reg <= '0; root_reg <= '0; span_reg <= '0; rcnt_reg <= '0;
            ci_reg <= '0; cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            hd_reg <= '0;
        end
        else
        begin
            if (crun_reg)
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                if (ci_reg == 5'(CORDIC_STEPS - 1))
                    crun_reg <= 1'b0;
                else
                    ci_reg <= ci_reg + 5'd1;
            end

            unique case (cstate_reg)
                C_IDLE, C_DONE:
                begin
                    if (start)
                    begin
                        adx_reg  <= adx;
                        ady_reg  <= ady;
                        negx_reg <= negx;
                        negy_reg <= negy;
                        zero_reg <= (adx == '0) && (ady == '0);
                        dvx_reg  <= (cfg.step_x == '0) ? STEP_W'(1) : cfg.step_x;
                        dvy_reg  <= (cfg.step_y == '0) ? STEP_W'(1) : cfg.step_y;
                        cx_reg   <= $signed(CDW'({adx, 16'b0}));
                        cy_reg   <= $signed(CDW'({ady, 16'b0}));
                        cz_reg   <= '0;
                        ci_reg   <= '0;
                        crun_reg <= 1'b1;
                        cstate_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    nx_reg   <= adx_reg * cfg.scale_meters;
                    ny_reg   <= ady_reg * cfg.scale_meters;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    dcnt_reg <= PCW'(P - 1);
                    cstate_reg <= C_DIV;
                end
                C_DIV:
                begin
                    rx_reg <= gex ? STEP_W'(shx - {1'b0, dvx_reg}) : shx[STEP_W-1:0];
                    ry_reg <= gey ? STEP_W'(shy - {1'b0, dvy_reg}) : shy[STEP_W-1:0];
                    nx_reg <= {nx_reg[P-2:0], gex};
                    ny_reg <= {ny_reg[P-2:0], gey};
                    if (dcnt_reg == '0)
                        cstate_reg <= C_SQ;
                    else
                        dcnt_reg <= dcnt_reg - PCW'(1);
                end
                C_SQ:
                begin
                    sqx_reg <= nx_reg[31:0] * nx_reg[31:0];
                    sqy_reg <= ny_reg[31:0] * ny_reg[31:0];
                    sat_reg <= ((nx_reg >> 32) != '0) || ((ny_reg >> 32) != '0);
                    hd_reg  <= hd;
                    cstate_reg <= C_SUM;
                end
                C_SUM:
                begin
                    sat_reg  <= sat_reg | ssum[64];
                    rad_reg  <= ssum[63:0];
                    rem_reg  <= '0;
                    root_reg <= '0;
                    rcnt_reg <= 5'd31;
                    cstate_reg <= C_ROOT;
                end
                C_ROOT:
                begin
                    rem_reg  <= rge ? 34'(rsh - trial) : rsh[33:0];
                    root_reg <= {root_reg[30:0], rge};
                    rad_reg  <= {rad_reg[61:0], 2'b00};
                    if (rcnt_reg == 5'd0)
                    begin
                        span_reg   <= sat_reg ? 32'hFFFF_FFFF : {root_reg[30:0], rge};
                        cstate_reg <= C_DONE;
                    end
                    else
                        rcnt_reg <= rcnt_reg - 5'd1;
                end
                default: cstate_reg <= C_IDLE;
            endcase
        end
    end

    assign done        = cstate_reg == C_DONE;
    assign heading_deg = hd_reg;
    assign span_dist   = span_reg;

endmodule

/* rtl/tcs_ctrl.sv */
// Box tracking and item sequencer: grows the bounding box, decides when a
// cube closes, drives tcs_calc and holds the result beat. Depends on tcs_pkg.
module tcs_ctrl #(
    parameter int COORD_BITS = 25,
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcs_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic [16:0]           point_time,
    input  logic                  is_last,
    output logic                  calc_start,
    input  logic                  calc_done,
    output logic [COORD_BITS-1:0] first_x,
    output logic [COORD_BITS-1:0] first_y,
    output logic [COORD_BITS-1:0] final_x,
    output logic [COORD_BITS-1:0] final_y,
    input  logic signed [8:0]     heading_deg,
    input  logic [31:0]           span_dist,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           cube_index,
    output logic [COORD_BITS-1:0] center_x,
    output logic [COORD_BITS-1:0] center_y,
    output logic [16:0]           center_time,
    output logic signed [8:0]     out_heading,
    output logic [31:0]           out_span,
    output logic [15:0]           owner_user,
    output logic [15:0]           owner_traj,
    output logic                  last_of_run
);
    import tcs_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int CW = (C > STEP_W) ? C : STEP_W;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_START, S_RUN, S_PUT} state_t;
    state_t state_reg;

    logic [C-1:0]          px_reg, py_reg;
    logic [TIME_W-1:0]     pt_reg;
    logic                  plast_reg;
    logic [C-1:0]          minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic [C-1:0]          fx_reg, fy_reg, lx_reg, ly_reg;
    logic [TIME_W-1:0]     ft_reg, lt_reg;
    logic [INDEX_BITS-1:0] cnt_reg, idx_reg;
    logic                  open_reg, emit_last_reg, second_reg, reopen_reg, close_reg;
    logic [C-1:0]          cenx_reg, ceny_reg;
    logic [TIME_W-1:0]     cent_reg;
    logic                  ov_reg, olast_reg;
    logic [15:0]           oidx_reg, ouser_reg, otraj_reg;
    logic [C-1:0]          ocx_reg, ocy_reg;
    logic [TIME_W-1:0]     oct_reg;
    logic signed [8:0]     ohd_reg;
    logic [31:0]           ospan_reg;

    logic gx, lsx, gy, lsy, x_ok, y_ok, t_rej, ok;
    logic [C:0]      sumx, sumy;
    logic [TIME_W:0] sumt;

    assign gx  = px_reg > maxx_reg;
    assign lsx = px_reg < minx_reg;
    assign gy  = py_reg > maxy_reg;
    assign lsy = py_reg < miny_reg;

    always_comb
    begin
        if (gx)
            x_ok = CW'(px_reg - minx_reg) < CW'(cfg.step_x);
        else if (lsx)
            x_ok = CW'(maxx_reg - px_reg) < CW'(cfg.step_x);
        else
            x_ok = 1'b1;
        if (gy)
            y_ok = CW'(py_reg - miny_reg) < CW'(cfg.step_y);
        else if (lsy)
            y_ok = CW'(maxy_reg - py_reg) < CW'(cfg.step_y);
        else
            y_ok = 1'b1;
    end

    // time going backwards never closes the box
    assign t_rej = (pt_reg >= ft_reg) && (TW_W'(pt_reg - ft_reg) >= cfg.time_window);
    assign ok    = x_ok && y_ok && !t_rej;

    assign sumx = {1'b0, minx_reg} + {1'b0, maxx_reg};
    assign sumy = {1'b0, miny_reg} + {1'b0, maxy_reg};
    assign sumt = {1'b0, ft_reg} + {1'b0, lt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            px_reg <= '0; py_reg <= '0; pt_reg <= '0; plast_reg <= 1'b0;
            minx_reg <= '0; maxx_reg <= '0; miny_reg <= '0; maxy_reg <= '0;
            fx_reg <= '0; fy_reg <= '0; ft_reg <= '0;
            lx_reg <= '0; ly_reg <= '0; lt_reg <= '0;
            cnt_reg <= '0; idx_reg <= '0; open_reg <= 1'b0;
            emit_last_reg <= 1'b0; second_reg <= 1'b0;
            reopen_reg <= 1'b0; close_reg <= 1'b0;
            cenx_reg <= '0; ceny_reg <= '0; cent_reg <= '0;
            ov_reg <= 1'b0; olast_reg <= 1'b0; oidx_reg <= '0;
            ouser_reg <= '0; otraj_reg <= '0; ocx_reg <= '0; ocy_reg <= '0;
            oct_reg <= '0; ohd_reg <= '0; ospan_reg <= '0;
        end
        else
        begin
            // drop the beat once taken; S_PUT handles the register itself
            if (ov_reg && out_ready && (state_reg != S_PUT))
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg    <= point_x;
                        py_reg    <= point_y;
                        pt_reg    <= point_time;
                        plast_reg <= is_last;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (!open_reg || ok)
                    begin
                        if (!open_reg)
                        begin
                            minx_reg <= px_reg; maxx_reg <= px_reg; fx_reg <= px_reg;
                            miny_reg <= py_reg; maxy_reg <= py_reg; fy_reg <= py_reg;
                            ft_reg   <= pt_reg;
                            open_reg <= 1'b1;
                        end
                        else
                        begin
                            if (lsx) minx_reg <= px_reg;
                            if (gx)  maxx_reg <= px_reg;
                            if (lsy) miny_reg <= py_reg;
                            if (gy)  maxy_reg <= py_reg;
                        end
                        lx_reg <= px_reg;
                        ly_reg <= py_reg;
                        lt_reg <= pt_reg;
                        emit_last_reg <= 1'b1;
                        close_reg     <= 1'b1;
                        reopen_reg    <= 1'b0;
                        second_reg    <= 1'b0;
                        state_reg     <= plast_reg ? S_START : S_IDLE;
                    end
                    else
                    begin
                        // close the old box first, reopen with this point after
                        emit_last_reg <= !plast_reg;
                        reopen_reg    <= 1'b1;
                        close_reg     <= 1'b0;
                        second_reg    <= plast_reg;
                        state_reg     <= S_START;
                    end
                end
                S_START:
                begin
                    cenx_reg <= sumx[C:1];
                    ceny_reg <= sumy[C:1];
                    cent_reg <= sumt[TIME_W:1];
                    idx_reg  <= cnt_reg + INDEX_BITS'(1);
                    cnt_reg  <= cnt_reg + INDEX_BITS'(1);
                    if (reopen_reg)
                    begin
                        minx_reg <= px_reg; maxx_reg <= px_reg; fx_reg <= px_reg;
                        miny_reg <= py_reg; maxy_reg <= py_reg; fy_reg <= py_reg;
                        ft_reg   <= pt_reg;
                        lx_reg   <= px_reg; ly_reg <= py_reg; lt_reg <= pt_reg;
                        reopen_reg <= 1'b0;
                    end
                    if (close_reg)
                    begin
                        open_reg <= 1'b0;
                        cnt_reg  <= '0;
                    end
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (calc_done)
                        state_reg <= S_PUT;
                end
                S_PUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg    <= 1'b1;
                        oidx_reg  <= 16'(idx_reg);
                        ocx_reg   <= cenx_reg;
                        ocy_reg   <= ceny_reg;
                        oct_reg   <= cent_reg;
                        ohd_reg   <= heading_deg;
                        ospan_reg <= span_dist;
                        ouser_reg <= cfg.user_id;
                        otraj_reg <= cfg.traj_id;
                        olast_reg <= emit_last_reg;
                        if (second_reg)
                        begin
                            second_reg    <= 1'b0;
                            emit_last_reg <= 1'b1;
                            close_reg     <= 1'b1;
                            state_reg     <= S_START;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready    = state_reg == S_IDLE;
    assign calc_start  = state_reg == S_START;
    assign first_x     = fx_reg;
    assign first_y     = fy_reg;
    assign final_x     = lx_reg;
    assign final_y     = ly_reg;
    assign out_valid   = ov_reg;
    assign cube_index  = oidx_reg;
    assign center_x    = ocx_reg;
    assign center_y    = ocy_reg;
    assign center_time = oct_reg;
    assign out_heading = ohd_reg;
    assign out_span    = ospan_reg;
    assign owner_user  = ouser_reg;
    assign owner_traj  = otraj_reg;
    assign last_of_run = olast_reg;

endmodule

/* rtl/trajectory_cube_segmenter.sv */
// A cube beat waits on the serial divider (COORD_BITS + 16 steps) and the
// 32-step square root, run one after the other.
// A point that closes a box and ends the run yields two beats.
// Throughput: one point at a time. Reset clears all registers at once; no sweep.
module trajectory_cube_segmenter #(
    parameter int COORD_BITS = 25,
    parameter int INDEX_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // points in; s_tdata: point_x, point_y, point_time (low to high), zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((2*COORD_BITS+17+7)/8)*8-1:0] s_tdata,
    input  logic        s_tlast,    // is_last
    // cubes out; m_tdata: cube_index, center_x, center_y, center_time,
    // heading_deg, span_dist, owner_user, owner_traj (low to high), zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((2*COORD_BITS+106+7)/8)*8-1:0] m_tdata,
    output logic        m_tlast     // last_of_run
);
    import tcs_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((2*COORD_BITS+106+7)/8)*8;

    cfg_t cfg_reg;

    // register bank; writes beyond the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_x       <= STEP_W'(100);
            cfg_reg.step_y       <= STEP_W'(100);
            cfg_reg.time_window  <= TW_W'(60);
            cfg_reg.scale_meters <= SCALE_W'(1000);
            cfg_reg.user_id      <= '0;
            cfg_reg.traj_id      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_STEP_X:       cfg_reg.step_x       <= cfg_data;
                REG_STEP_Y:       cfg_reg.step_y       <= cfg_data;
                REG_TIME_WINDOW:  cfg_reg.time_window  <= cfg_data[TW_W-1:0];
                REG_SCALE_METERS: cfg_reg.scale_meters <= cfg_data[SCALE_W-1:0];
                REG_USER_ID:      cfg_reg.user_id      <= cfg_data[ID_W-1:0];
                REG_TRAJ_ID:      cfg_reg.traj_id      <= cfg_data[ID_W-1:0];
                default:          ;
            endcase
        end
    end

    logic                  calc_start, calc_done;
    logic [C-1:0]          first_x, first_y, final_x, final_y;
    logic signed [8:0]     heading_deg, out_heading;
    logic [31:0]           span_dist, out_span;
    logic [15:0]           cube_index, owner_user, owner_traj;
    logic [C-1:0]          center_x, center_y;
    logic [16:0]           center_time;

    tcs_ctrl #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .point_x     (s_tdata[C-1:0]),
        .point_y     (s_tdata[2*C-1:C]),
        .point_time  (s_tdata[2*C+16:2*C]),
        .is_last     (s_tlast),
        .calc_start  (calc_start),
        .calc_done   (calc_done),
        .first_x     (first_x),
        .first_y     (first_y),
        .final_x     (final_x),
        .final_y     (final_y),
        .heading_deg (heading_deg),
        .span_dist   (span_dist),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .cube_index  (cube_index),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_time (center_time),
        .out_heading (out_heading),
        .out_span    (out_span),
        .owner_user  (owner_user),
        .owner_traj  (owner_traj),
        .last_of_run (m_tlast)
    );

    tcs_calc #(
        .COORD_BITS (COORD_BITS)
    ) u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (calc_start),
        .first_x     (first_x),
        .first_y     (first_y),
        .final_x     (final_x),
        .final_y     (final_y),
        .cfg         (cfg_reg),
        .done        (calc_done),
        .heading_deg (heading_deg),
        .span_dist   (span_dist)
    );

    // pack the result beat, zero pad on top
    assign m_tdata = OUT_W'({owner_traj, owner_user, out_span, out_heading,
                             center_time, center_y, center_x, cube_index});

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for trajectory_cube_segmenter: points in, cubes out, both streamed.
// Depends on tcs_pkg and the segmenter RTL; an in-bench box/CORDIC/sqrt predictor checks cubes.
module tb_top;
    import tcs_pkg::*;

    localparam int SW = 72;
    localparam int MW = 160;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        bit [15:0]       idx;
        bit [24:0]       cx;
        bit [24:0]       cy;
        bit [16:0]       ct;
        bit signed [8:0] head;
        bit [31:0]       spn;
        bit [15:0]       usr;
        bit [15:0]       trj;
        bit              last;
    } cube_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [2:0]      cfg_index;
    logic [23:0]     cfg_data;
    logic            s_tvalid;
    logic            s_tready;
    logic [SW-1:0]   s_tdata;    // point_x[24:0], point_y[49:25], point_time[66:50], pad
    logic            s_tlast;
    logic            m_tvalid;
    logic            m_tready;
    logic [MW-1:0]   m_tdata;    // cube_index, center_x, center_y, center_time,
                                 // heading_deg, span_dist, owner_user, owner_traj, pad
    logic            m_tlast;

    trajectory_cube_segmenter DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // predictor copy of the register bank and the box state
    bit [23:0] step_x_r, step_y_r;
    bit [16:0] window_r;
    bit [15:0] scale_r, user_r, traj_r;
    bit [24:0] bmin_x, bmax_x, bmin_y, bmax_y, org_x, org_y, end_x, end_y;
    bit [16:0] org_t, end_t;
    bit [15:0] cube_cnt;
    bit        box_live;

    cube_t pending_cubes[$];
    int    errors;
    bit    no_idle;        // run a stretch with no gaps on either side
    bit    rx_hold_req;    // ask the receiver for a long hold-off
    longint cycles;

    const longint atan_tab[22] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int bearing(bit [24:0] ax0, bit [24:0] ay0, bit [24:0] ax1,
                                   bit [24:0] ay1);
        longint dx, dy, x, y, z, xs, ys, m;
        dx = longint'(ax1) - longint'(ax0);
        dy = longint'(ay1) - longint'(ay0);
        if (dx == 0 && dy == 0)
            return 0;
        x = (dx < 0 ? -dx : dx) <<< 16;
        y = (dy < 0 ? -dy : dy) <<< 16;
        z = 0;
        for (int i = 0; i < 22; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += atan_tab[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 90 * 65536) z = 90 * 65536;
        m = (dx < 0) ? 180 * 65536 - z : z;
        if (dy >= 0)
            return int'((m + 32768) >>> 16);
        if (m < 32768)
            return 0;
        return -int'((m - 32768) >>> 16);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [31:0] span_of();
        longint unsigned ddx, ddy, ax, ay, sa, s;
        ddx = end_x > org_x ? end_x - org_x : org_x - end_x;
        ddy = end_y > org_y ? end_y - org_y : org_y - end_y;
        ax = ddx * scale_r / (step_x_r != 0 ? step_x_r : 1);
        ay = ddy * scale_r / (step_y_r != 0 ? step_y_r : 1);
        if (ax > 64'hFFFFFFFF || ay > 64'hFFFFFFFF)
            return '1;
        sa = ax * ax;
        s = sa + ay * ay;
        if (s < sa)
            return '1;
        return 32'(root_floor(s));
    endfunction

    function automatic void close_cube(bit last);
        cube_t c;
        cube_cnt++;
        c.idx  = cube_cnt;
        c.cx   = (26'(bmin_x) + bmax_x) >> 1;
        c.cy   = (26'(bmin_y) + bmax_y) >> 1;
        c.ct   = (18'(org_t) + end_t) >> 1;
        c.head = 9'(bearing(org_x, org_y, end_x, end_y));
        c.spn  = span_of();
        c.usr  = user_r;
        c.trj  = traj_r;
        c.last = last;
        pending_cubes.insert(pending_cubes.size(), c);
    endfunction

    function automatic void start_box(bit [24:0] x, bit [24:0] y, bit [16:0] t);
        bmin_x = x; bmax_x = x; org_x = x;
        bmin_y = y; bmax_y = y; org_y = y;
        org_t = t;
        box_live = 1;
    endfunction

    // advance the box state by one accepted point
    function automatic void absorb_point(bit [24:0] x, bit [24:0] y, bit [16:0] t, bit last);
        bit ok;
        bit [24:0] nminx, nmaxx, nminy, nmaxy;
        if (!box_live)
            start_box(x, y, t);
        else
        begin
            ok = 1;
            nminx = bmin_x; nmaxx = bmax_x; nminy = bmin_y; nmaxy = bmax_y;
            if (x > bmax_x)
            begin
                if (x - bmin_x < step_x_r) nmaxx = x; else ok = 0;
            end
            else if (x < bmin_x)
            begin
                if (bmax_x - x < step_x_r) nminx = x; else ok = 0;
            end
            if (ok)
            begin
                if (y > bmax_y)
                begin
                    if (y - bmin_y < step_y_r) nmaxy = y; else ok = 0;
                end
                else if (y < bmin_y)
                begin
                    if (bmax_y - y < step_y_r) nminy = y; else ok = 0;
                end
            end
            // time going backwards never closes the box
            if (ok && longint'(t) - longint'(org_t) >= longint'(window_r))
                ok = 0;
            if (ok)
            begin
                bmin_x = nminx; bmax_x = nmaxx; bmin_y = nminy; bmax_y = nmaxy;
            end
            else
            begin
                close_cube(!last);
                start_box(x, y, t);
            end
        end
        end_x = x; end_y = y; end_t = t;
        if (last)
        begin
            close_cube(1);
            box_live = 0;
            cube_cnt = 0;
        end
    endfunction

    // send one point beat; valid stays high after acceptance until the next call
    task automatic send_point(bit [24:0] x, bit [24:0] y, bit [16:0] t, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, t, y, x};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        absorb_point(x, y, t, last);
    endtask

    // drop valid, wait for all cubes, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_cubes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, bit [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_STEP_X:       step_x_r = val;
            REG_STEP_Y:       step_y_r = val;
            REG_TIME_WINDOW:  window_r = val[16:0];
            REG_SCALE_METERS: scale_r  = val[15:0];
            REG_USER_ID:      user_r   = val[15:0];
            REG_TRAJ_ID:      traj_r   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(bit [23:0] sx, bit [23:0] sy, bit [16:0] tw, bit [15:0] sc);
        wait_idle();
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_TIME_WINDOW, 24'(tw));
        write_reg(REG_SCALE_METERS, 24'(sc));
        write_reg(REG_USER_ID, $urandom_range(0, 65535));
        write_reg(REG_TRAJ_ID, $urandom_range(0, 65535));
    endtask

    // receiver: random stalls per beat, long hold-off on request, check every beat
    initial
    begin : rx_side
        int stall;
        cube_t e;
        bit [15:0] g_idx, g_usr, g_trj;
        bit [24:0] g_cx, g_cy;
        bit [16:0] g_ct;
        bit signed [8:0] g_head;
        bit [31:0] g_dist;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                {g_trj, g_usr, g_dist, g_head, g_ct, g_cy, g_cx, g_idx} = m_tdata[155:0];
                if (pending_cubes.size() == 0)
                begin
                    $display("%0t: unexpected cube beat %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    e = pending_cubes.pop_front();
                    if (g_idx !== e.idx || g_cx !== e.cx || g_cy !== e.cy || g_ct !== e.ct ||
                        g_head !== e.head || g_dist !== e.spn || g_usr !== e.usr ||
                        g_trj !== e.trj || m_tlast !== e.last)
                    begin
                        $display("%0t: cube mismatch exp idx=%0d c=(%0d,%0d,%0d) hd=%0d d=%0d u=%0d t=%0d l=%0d",
                                 $time, e.idx, e.cx, e.cy, e.ct, e.head, e.spn, e.usr,
                                 e.trj, e.last);
                        $display("%0t:               got idx=%0d c=(%0d,%0d,%0d) hd=%0d d=%0d u=%0d t=%0d l=%0d",
                                 $time, g_idx, g_cx, g_cy, g_ct, g_head, g_dist, g_usr,
                                 g_trj, m_tlast);
                        errors++;
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (rx_hold_req)
            begin
                // hold off long enough for the input side to back up
                m_tready <= 1'b0;
                repeat (1500) @(posedge clk);
                rx_hold_req = 0;
                stall = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        write_reg(REG_USER_ID, 24'hFFFF);
        write_reg(REG_TRAJ_ID, 24'h1234);
        send_point(1000, 1000, 0, 0);     // opens the box
        send_point(1050, 1020, 10, 0);
        send_point(1099, 1000, 20, 0);    // just inside x limit
        send_point(1100, 1000, 25, 0);    // x limit reached
        send_point(1100, 950, 5, 0);      // time running backwards
        send_point(1100, 1051, 100, 0);   // y limit reached
        send_point(1101, 1051, 160, 0);   // time window reached
        send_point(0, 0, 170, 1);         // reject plus flush: two cubes
        send_point(25'h1FFFFFF, 25'h1FFFFFF, 86400, 1);  // one-point box
        // every octant of the heading
        for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
                if (dx != 0 || dy != 0)
                begin
                    send_point(5000, 5000, 0, 0);
                    send_point(25'(5000 + 40 * dx), 25'(5000 + 40 * dy), 1, 1);
                end
    endtask

    task automatic test_zero_regs();
        // zero steps accept no widening; zero window closes every later point
        write_all(0, 0, 0, 7);
        send_point(200, 300, 10, 0);
        send_point(200, 300, 10, 0);
        send_point(201, 300, 9, 0);
        send_point(201, 299, 9, 1);
    endtask

    task automatic test_extremes();
        write_all(1, 1, 86400, 65535);   // saturating distance
        send_point(0, 0, 0, 0);
        send_point(25'h1FFFFFF, 25'h1FFFFFF, 86400, 1);
        send_point(0, 25'h1FFFFFF, 0, 0);
        send_point(25'h1FFFFFF, 0, 5, 1);
        write_all(24'hFFFFFF, 24'hFFFFFF, 86400, 65535);
        send_point(0, 0, 0, 0);
        send_point(25'h1FFFFFF, 25'h1FFFFFF, 86399, 0);
        send_point(1, 2, 86400, 1);
    endtask

    // well-formed random walks, with some noise points thrown in
    task automatic random_walks(int count);
        longint x, y, t, sx, sy;
        bit last;
        sx = step_x_r == 0 ? 4 : (step_x_r > 100000 ? 100000 : step_x_r);
        sy = step_y_r == 0 ? 4 : (step_y_r > 100000 ? 100000 : step_y_r);
        x = $urandom_range(0, 25'h1FFFFFF);
        y = $urandom_range(0, 25'h1FFFFFF);
        t = $urandom_range(0, 80000);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_point($urandom_range(0, 25'h1FFFFFF), $urandom_range(0, 25'h1FFFFFF),
                           $urandom_range(0, 86400), $urandom_range(0, 1));
            else
            begin
                x += longint'($urandom_range(0, 2 * sx / 3)) - sx / 3;
                y += longint'($urandom_range(0, 2 * sy / 3)) - sy / 3;
                t += longint'($urandom_range(0, window_r / 3 + 2)) - 1;
                if (x < 0) x = 0;
                if (x > 25'h1FFFFFF) x = 25'h1FFFFFF;
                if (y < 0) y = 0;
                if (y > 25'h1FFFFFF) y = 25'h1FFFFFF;
                if (t < 0) t = 0;
                if (t > 86400) t = 86400;
                last = $urandom_range(0, 24) == 0;
                send_point(25'(x), 25'(y), 17'(t), last);
            end
        end
    endtask

    task automatic test_backpressure();
        write_all(10, 10, 60, 1000);
        rx_hold_req = 1;
        no_idle = 1;
        for (int i = 0; i < 30; i++)
            send_point(25'(i * 50), 25'(i * 30), 17'(i), i % 7 == 6);
        no_idle = 0;
        // pause until every cube is out
        wait_idle();
        random_walks(20);
    endtask

    task automatic test_random();
        write_all(100, 100, 60, 1000);
        random_walks(150);
        write_all($urandom_range(1, 5000), $urandom_range(1, 5000),
                  $urandom_range(1, 600), $urandom_range(1, 65535));
        no_idle = 1;
        random_walks(60);
        no_idle = 0;
        random_walks(90);
        write_all($urandom_range(1, 16777215), $urandom_range(1, 300),
                  $urandom_range(1, 86400), $urandom_range(1, 65535));
        random_walks(150);
        write_all($urandom_range(1, 50), $urandom_range(1, 50), 3, 65535);
        random_walks(150);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 0;
        rx_hold_req = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        step_x_r = 100; step_y_r = 100; window_r = 60; scale_r = 1000;
        user_r = 0; traj_r = 0;
        {bmin_x, bmax_x, bmin_y, bmax_y, org_x, org_y, end_x, end_y} = '0;
        org_t = 0; end_t = 0; cube_cnt = 0; box_live = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_zero_regs();
        test_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
